[sv/pauli_rotation_pair_update_defines.svh]
// Assertion macros for the Pauli rotation pair update block.
`ifndef PAULI_ROTATION_PAIR_UPDATE_DEFINES_SVH
`define PAULI_ROTATION_PAIR_UPDATE_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Antecedent implies consequent in the same cycle (consequent may carry a delay).
`define PRPU_ASSERT_IMPLIES(label, clk_sig, rst_n_sig, ante, cons) \
	label: assert property (@(posedge clk_sig) disable iff (!rst_n_sig) \
		(ante) |-> cons) else $error("prpu assertion failed");

// Antecedent implies consequent in the following cycle.
`define PRPU_ASSERT_NEXT(label, clk_sig, rst_n_sig, ante, cons) \
	label: assert property (@(posedge clk_sig) disable iff (!rst_n_sig) \
		(ante) |=> (cons)) else $error("prpu assertion failed");

`else

`define PRPU_ASSERT_IMPLIES(label, clk_sig, rst_n_sig, ante, cons)
`define PRPU_ASSERT_NEXT(label, clk_sig, rst_n_sig, ante, cons)

`endif

`endif

[sv/prpu_pkg.sv]
// Shared constants, types and register codes of the Pauli rotation pair update block.
package prpu_pkg;

	localparam int QUBITS     = 20;
	localparam int AMP_WIDTH  = 32;
	localparam int FRAC_BITS  = AMP_WIDTH - 3;
	localparam int PROD_WIDTH = 2 * AMP_WIDTH;
	localparam int SUM_WIDTH  = PROD_WIDTH + 2;
	localparam int IDX_WIDTH  = QUBITS - 1;
	localparam int CFG_IDX_WIDTH  = 2;
	localparam int CFG_DATA_WIDTH = (AMP_WIDTH > QUBITS) ? AMP_WIDTH : QUBITS;

	typedef logic [QUBITS-1:0]           addr_t;
	typedef logic [IDX_WIDTH-1:0]        idx_t;
	typedef logic signed [AMP_WIDTH-1:0] amp_t;
	typedef logic [1:0]                  phase_t;

	typedef enum logic [CFG_IDX_WIDTH-1:0] {
		REG_X_MASK   = 2'd0,
		REG_Z_MASK   = 2'd1,
		REG_COS_HALF = 2'd2,
		REG_SIN_HALF = 2'd3
	} reg_index_t;

	// Addressing and phase control of one pair.
	typedef struct packed {
		addr_t  addr_a;
		addr_t  addr_b;
		phase_t phase_a;
		phase_t phase_b;
		logic   diag;
	} pair_ctl_t;

endpackage

[sv/prpu_addr.sv]
// Basis address and phase code generation for one amplitude pair.
module prpu_addr (
	input  prpu_pkg::idx_t    pair_index,
	input  prpu_pkg::addr_t   x_mask,
	input  prpu_pkg::addr_t   z_mask,
	output prpu_pkg::pair_ctl_t ctl
);

	localparam int CNT_WIDTH = $clog2(prpu_pkg::QUBITS + 1);

	prpu_pkg::addr_t      smear;
	prpu_pkg::addr_t      low_mask;
	prpu_pkg::addr_t      a;
	prpu_pkg::addr_t      b;
	logic [CNT_WIDTH-1:0] cnt;
	prpu_pkg::phase_t     g;
	logic                 diag;
	logic                 par_a;
	logic                 par_b;

	// Smear the highest set bit of the X mask down to bit zero.
	always_comb begin
		smear = x_mask;
		for (int j = 0; j < 6; j++) begin
			smear = smear | (smear >> (1 << j));
		end
	end

	assign low_mask = smear >> 1;
	assign diag     = (x_mask == '0);

	// Insert a zero at the X mask's top bit; with an empty mask this is 2k.
	assign a = ({pair_index, 1'b0} & ~smear) | ({1'b0, pair_index} & low_mask);
	assign b = diag ? (a | prpu_pkg::addr_t'(1)) : (a ^ x_mask);

	assign par_a = ^(a & z_mask);
	assign par_b = ^(b & z_mask);
	assign cnt   = CNT_WIDTH'($countones(x_mask & z_mask));
	assign g     = cnt[1:0];

	always_comb begin
		ctl.addr_a = a;
		ctl.addr_b = b;
		ctl.diag   = diag;
		if (diag) begin
			ctl.phase_a = par_a ? 2'd3 : 2'd1;
			ctl.phase_b = par_b ? 2'd3 : 2'd1;
		end else begin
			ctl.phase_a = 2'd1 - g - {par_a, 1'b0};
			ctl.phase_b = 2'd1 - g - {par_b, 1'b0};
		end
	end

endmodule

[sv/prpu_lane.sv]
// One rotation lane: cos*own + i^phase * sin*src, rounded and saturated.
module prpu_lane (
	input  logic               clk,
	input  prpu_pkg::amp_t     cos_half,
	input  prpu_pkg::amp_t     sin_half,
	input  prpu_pkg::amp_t     own_re,
	input  prpu_pkg::amp_t     own_im,
	input  prpu_pkg::amp_t     src_re,
	input  prpu_pkg::amp_t     src_im,
	input  prpu_pkg::phase_t   phase,
	output prpu_pkg::amp_t     res_re,
	output prpu_pkg::amp_t     res_im
);

	localparam int PW = prpu_pkg::PROD_WIDTH;
	localparam int SW = prpu_pkg::SUM_WIDTH;
	localparam int AW = prpu_pkg::AMP_WIDTH;
	localparam int FB = prpu_pkg::FRAC_BITS;
	localparam int SHW = SW - FB;

	logic signed [PW-1:0] cr_s2, ci_s2, tr_s2, ti_s2;
	prpu_pkg::phase_t     phase_s2;
	logic signed [SW-1:0] sum_re_s3, sum_im_s3;
	prpu_pkg::amp_t       res_re_s4, res_im_s4;

	logic signed [SW-1:0] cr_x, ci_x, sel_re, sel_im, add_re, add_im, half;

	function automatic prpu_pkg::amp_t sat(input logic signed [SHW-1:0] v);
		prpu_pkg::amp_t r;
		if (v[SHW-1:AW-1] == '0 || v[SHW-1:AW-1] == '1) begin
			r = v[AW-1:0];
		end else begin
			r = v[SHW-1] ? {1'b1, {(AW-1){1'b0}}} : {1'b0, {(AW-1){1'b1}}};
		end
		return r;
	endfunction

	// Stage 2: four full products.
	always_ff @(posedge clk) begin
		cr_s2    <= PW'(cos_half * own_re);
		ci_s2    <= PW'(cos_half * own_im);
		tr_s2    <= PW'(sin_half * src_re);
		ti_s2    <= PW'(sin_half * src_im);
		phase_s2 <= phase;
	end

	assign half = SW'(1) <<< (FB - 1);
	assign cr_x = SW'(cr_s2);
	assign ci_x = SW'(ci_s2);

	// Multiply by i^phase: swap on odd phase, negate as the phase demands.
	assign sel_re = phase_s2[0] ? SW'(ti_s2) : SW'(tr_s2);
	assign sel_im = phase_s2[0] ? SW'(tr_s2) : SW'(ti_s2);
	assign add_re = (phase_s2[1] ^ phase_s2[0]) ? -sel_re : sel_re;
	assign add_im = phase_s2[1] ? -sel_im : sel_im;

	// Stage 3: exact sum with half an LSB added for rounding.
	always_ff @(posedge clk) begin
		sum_re_s3 <= cr_x + add_re + half;
		sum_im_s3 <= ci_x + add_im + half;
	end

	// Stage 4: drop fraction bits and saturate.
	always_ff @(posedge clk) begin
		res_re_s4 <= sat(sum_re_s3[SW-1:FB]);
		res_im_s4 <= sat(sum_im_s3[SW-1:FB]);
	end

	assign res_re = res_re_s4;
	assign res_im = res_im_s4;

endmodule

[sv/pauli_rotation_pair_update.sv]
// Top level of the Pauli rotation pair update block.
//
// One amplitude pair is taken per clock: a transaction is accepted whenever start is high,
// and busy never rises. Each transaction's result is on the output ports for exactly one
// cycle, marked by done; the receiver cannot stall, so results must be captured as they
// come. The result leaves after the input capture register and the two rotation lanes,
// each a three-stage pipeline: a product stage of four 32x32 multipliers, an add-and-round
// stage and a saturation stage, and one pair per clock flows through them. The masks and
// the cosine and sine coefficients are written through the cfg port and must hold while
// pairs are in flight.
// Arithmetic is Q2.29, rounded half up and saturated.
`include "pauli_rotation_pair_update_defines.svh"

module pauli_rotation_pair_update (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      cfg_we,
	input  logic [prpu_pkg::CFG_IDX_WIDTH-1:0]        cfg_index,
	input  logic [prpu_pkg::CFG_DATA_WIDTH-1:0]       cfg_data,
	input  logic                                      start,
	output logic                                      busy,
	input  logic [prpu_pkg::IDX_WIDTH-1:0]            pair_index,
	input  logic signed [prpu_pkg::AMP_WIDTH-1:0]     amp_a_re,
	input  logic signed [prpu_pkg::AMP_WIDTH-1:0]     amp_a_im,
	input  logic signed [prpu_pkg::AMP_WIDTH-1:0]     amp_b_re,
	input  logic signed [prpu_pkg::AMP_WIDTH-1:0]     amp_b_im,
	output logic                                      done,
	output logic [prpu_pkg::QUBITS-1:0]               addr_a,
	output logic [prpu_pkg::QUBITS-1:0]               addr_b,
	output logic signed [prpu_pkg::AMP_WIDTH-1:0]     new_a_re,
	output logic signed [prpu_pkg::AMP_WIDTH-1:0]     new_a_im,
	output logic signed [prpu_pkg::AMP_WIDTH-1:0]     new_b_re,
	output logic signed [prpu_pkg::AMP_WIDTH-1:0]     new_b_im
);

	// Configuration registers.
	prpu_pkg::addr_t x_mask_q, z_mask_q;
	prpu_pkg::amp_t  cos_half_q, sin_half_q;

	// Pipeline.
	logic                v_s1, v_s2, v_s3, v_s4;
	prpu_pkg::pair_ctl_t ctl_in, ctl_s1;
	prpu_pkg::amp_t      a_re_s1, a_im_s1, b_re_s1, b_im_s1;
	prpu_pkg::addr_t     addr_a_s2, addr_b_s2, addr_a_s3, addr_b_s3, addr_a_s4, addr_b_s4;
	prpu_pkg::amp_t      src_a_re, src_a_im, src_b_re, src_b_im;
	logic                accept;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	// Register writes; an index outside the list is dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_mask_q   <= '0;
			z_mask_q   <= '0;
			cos_half_q <= '0;
			sin_half_q <= '0;
		end else if (cfg_we) begin
			case (prpu_pkg::reg_index_t'(cfg_index))
				prpu_pkg::REG_X_MASK:   x_mask_q   <= cfg_data[prpu_pkg::QUBITS-1:0];
				prpu_pkg::REG_Z_MASK:   z_mask_q   <= cfg_data[prpu_pkg::QUBITS-1:0];
				prpu_pkg::REG_COS_HALF: cos_half_q <= cfg_data[prpu_pkg::AMP_WIDTH-1:0];
				prpu_pkg::REG_SIN_HALF: sin_half_q <= cfg_data[prpu_pkg::AMP_WIDTH-1:0];
				default: ;
			endcase
		end
	end

	// Addresses and phase codes come straight from the incoming index.
	prpu_addr u_addr (
		.pair_index (pair_index),
		.x_mask     (x_mask_q),
		.z_mask     (z_mask_q),
		.ctl        (ctl_in)
	);

	// Valid chain: advance one stage per clock, never held.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// Stage 1: capture the transaction.
	always_ff @(posedge clk) begin
		if (accept) begin
			ctl_s1  <= ctl_in;
			a_re_s1 <= amp_a_re;
			a_im_s1 <= amp_a_im;
			b_re_s1 <= amp_b_re;
			b_im_s1 <= amp_b_im;
		end
	end

	// Diagonal operator: each amplitude only rotates against itself.
	// Otherwise each lane mixes in the partner amplitude.
	assign src_a_re = ctl_s1.diag ? a_re_s1 : b_re_s1;
	assign src_a_im = ctl_s1.diag ? a_im_s1 : b_im_s1;
	assign src_b_re = ctl_s1.diag ? b_re_s1 : a_re_s1;
	assign src_b_im = ctl_s1.diag ? b_im_s1 : a_im_s1;

	prpu_lane u_lane_a (
		.clk      (clk),
		.cos_half (cos_half_q),
		.sin_half (sin_half_q),
		.own_re   (a_re_s1),
		.own_im   (a_im_s1),
		.src_re   (src_a_re),
		.src_im   (src_a_im),
		.phase    (ctl_s1.phase_a),
		.res_re   (new_a_re),
		.res_im   (new_a_im)
	);

	prpu_lane u_lane_b (
		.clk      (clk),
		.cos_half (cos_half_q),
		.sin_half (sin_half_q),
		.own_re   (b_re_s1),
		.own_im   (b_im_s1),
		.src_re   (src_b_re),
		.src_im   (src_b_im),
		.phase    (ctl_s1.phase_b),
		.res_re   (new_b_re),
		.res_im   (new_b_im)
	);

	// Carry the addresses alongside the lanes so they merge with the rotated values.
	always_ff @(posedge clk) begin
		addr_a_s2 <= ctl_s1.addr_a;
		addr_b_s2 <= ctl_s1.addr_b;
		addr_a_s3 <= addr_a_s2;
		addr_b_s3 <= addr_b_s2;
		addr_a_s4 <= addr_a_s3;
		addr_b_s4 <= addr_b_s3;
	end

	assign addr_a = addr_a_s4;
	assign addr_b = addr_b_s4;
	assign done   = v_s4;

	// Every accepted transaction yields its result, marked by done.
	`PRPU_ASSERT_IMPLIES(a_latency, clk, arst_n, start && !busy, ##4 done)
	// No result without an earlier accepted transaction.
	`PRPU_ASSERT_IMPLIES(a_no_spurious, clk, arst_n, done, $past(start && !busy, 4))
	// The two basis addresses of a pair always differ.
	`PRPU_ASSERT_NEXT(a_addr_distinct, clk, arst_n, v_s3, addr_a != addr_b)

endmodule
